[sv/ilid_pkg.sv]
package ilid_pkg;

    localparam int unsigned DEPTH_DEFAULT = 16;

    localparam int unsigned TYPE_W  = 3;
    localparam int unsigned POS_W   = 8;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned COUNT_W = 9;

    localparam logic [TYPE_W-1:0] REQ_READ     = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_INS_HEAD = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_INS_TAIL = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_INS_POS  = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_DELETE   = 3'd4;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    localparam logic signed [VALUE_W-1:0] READ_MISS = -32'sd1;

    typedef struct packed {
        logic [TYPE_W-1:0]         req_type;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] value_in;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic signed [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0]        entry_count;
    } rsp_t;

endpackage

[sv/ilid_store.sv]
module ilid_store #(
    parameter int unsigned DEPTH = ilid_pkg::DEPTH_DEFAULT
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  ilid_pkg::req_t req,
    output ilid_pkg::rsp_t rsp
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [ilid_pkg::COUNT_W-1:0] DEPTH_C = ilid_pkg::COUNT_W'(DEPTH);

    logic [CNT_W-1:0]                     count_reg;
    logic [CNT_W-1:0]                     count_next;
    logic signed [ilid_pkg::VALUE_W-1:0]  store_reg  [DEPTH];
    logic signed [ilid_pkg::VALUE_W-1:0]  store_next [DEPTH];
    logic [ilid_pkg::COUNT_W-1:0]         cnt_ext;
    logic [ilid_pkg::COUNT_W-1:0]         pos_ext;
    logic [ilid_pkg::COUNT_W-1:0]         ins_pos;
    logic [IDX_W-1:0]                     rd_idx;
    logic                                 is_ins;
    logic                                 full;
    logic                                 hit;
    logic                                 ins_ok;
    logic                                 del_ok;

    always_comb begin
        cnt_ext        = ilid_pkg::COUNT_W'(count_reg);
        pos_ext        = ilid_pkg::COUNT_W'(req.position);
        full           = (cnt_ext == DEPTH_C);
        hit            = (pos_ext < cnt_ext);
        rd_idx         = pos_ext[IDX_W-1:0];
        is_ins         = 1'b0;
        ins_pos        = pos_ext;
        ins_ok         = 1'b0;
        del_ok         = 1'b0;
        rsp.status     = ilid_pkg::ST_DONE;
        rsp.read_value = '0;
        case (req.req_type)
            ilid_pkg::REQ_READ: begin
                if (hit) begin
                    rsp.read_value = store_reg[rd_idx];
                end else begin
                    rsp.read_value = ilid_pkg::READ_MISS;
                    rsp.status     = ilid_pkg::ST_RANGE;
                end
            end
            ilid_pkg::REQ_INS_HEAD: begin
                is_ins  = 1'b1;
                ins_pos = '0;
            end
            ilid_pkg::REQ_INS_TAIL: begin
                is_ins  = 1'b1;
                ins_pos = cnt_ext;
            end
            ilid_pkg::REQ_INS_POS: begin
                is_ins = 1'b1;
            end
            ilid_pkg::REQ_DELETE: begin
                if (hit) begin
                    del_ok = 1'b1;
                end else begin
                    rsp.status = ilid_pkg::ST_RANGE;
                end
            end
            default: begin
                rsp.status = ilid_pkg::ST_RANGE;
            end
        endcase
        if (is_ins) begin
            if (ins_pos > cnt_ext) begin
                rsp.status = ilid_pkg::ST_RANGE;
            end else if (full) begin
                rsp.status = ilid_pkg::ST_FULL;
            end else begin
                ins_ok = 1'b1;
            end
        end
        count_next = count_reg;
        if (ins_ok) begin
            count_next = count_reg + CNT_W'(1);
        end else if (del_ok) begin
            count_next = count_reg - CNT_W'(1);
        end
        rsp.entry_count = ilid_pkg::COUNT_W'(count_next);
    end

    // open a gap on insert, close it on delete
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            store_next[i] = store_reg[i];
            if (ins_ok && ilid_pkg::COUNT_W'(i) == ins_pos) begin
                store_next[i] = req.value_in;
            end else if (ins_ok && ilid_pkg::COUNT_W'(i) > ins_pos) begin
                store_next[i] = store_reg[(i == 0) ? 0 : i - 1];
            end else if (del_ok && ilid_pkg::COUNT_W'(i) >= pos_ext) begin
                store_next[i] = store_reg[(i == DEPTH - 1) ? i : i + 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (en) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            store_reg <= store_next;
        end
    end

    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(count_reg))
        else $error("entry count moved without a request");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ilid_pkg::COUNT_W'(count_reg) <= DEPTH_C)
        else $error("entry count beyond depth");

    a_full_no_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        en && full |-> !ins_ok)
        else $error("insert accepted into a full list");

endmodule

[sv/indexed_list_insert_delete_core.sv]
// Indexed ordered list of up to DEPTH signed 32-bit entries.
// Slave channel: one request per transfer. s_tuser carries req_type (read,
// insert head, insert tail, insert at position, delete at position);
// s_tdata carries position [7:0] and value_in [39:8].
// Master channel: one result per request, in order. m_tuser carries status
// (done, out of range, full); m_tdata carries read_value [31:0] and
// entry_count [40:32], the count held after the request.
// Pipeline: a request is held in the input register, then its result in the
// result register that drives the master channel, two register stages in all.
// Throughput: one request per cycle unless m_tready stalls; every entry shifts
// in parallel, so the input and result registers are the only pipeline stages.
// Reset (aresetn low, synchronous) empties the list and drops anything held
// in either register; stored values are not cleared and are never read
// before being written.
// When the receiver stalls, the result holds on the master side, one more
// request may wait in the input register, then s_tready falls.
module indexed_list_insert_delete_core #(
    parameter int unsigned DEPTH = ilid_pkg::DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position [7:0], value_in [39:8]
    input  logic [2:0]  s_tuser,   // req_type [2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // read_value [31:0], entry_count [40:32], zero fill
    output logic [1:0]  m_tuser    // status [1:0]
);

    logic           in_valid_reg;
    ilid_pkg::req_t in_req_reg;
    logic           out_valid_reg;
    ilid_pkg::rsp_t out_rsp_reg;
    ilid_pkg::rsp_t rsp;
    logic           advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    ilid_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .req     (in_req_reg),
        .rsp     (rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_req_reg.req_type <= s_tuser;
            in_req_reg.position <= s_tdata[7:0];
            in_req_reg.value_in <= s_tdata[39:8];
        end
        if (advance) begin
            out_rsp_reg <= rsp;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_rsp_reg.status;
    assign m_tdata  = {7'b0, out_rsp_reg.entry_count, out_rsp_reg.read_value};

    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("result register not loaded after a transfer");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_rsp_reg.status == ilid_pkg::ST_FULL
        |-> out_rsp_reg.entry_count == ilid_pkg::COUNT_W'(DEPTH))
        else $error("full status with list not full");

    a_nonread_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_req_reg.req_type != ilid_pkg::REQ_READ
        |=> out_rsp_reg.read_value == '0)
        else $error("read value set on a non-read request");

endmodule
